// ----- rtl/core/swlc_pkg.sv -----
package swlc_pkg;

    localparam int MAX_WAYS        = 8;
    localparam int MAX_SETS        = 32;
    localparam int MAX_BLOCK_WORDS = 16;

    localparam int WAY_W  = $clog2(MAX_WAYS);
    localparam int SET_W  = $clog2(MAX_SETS);
    localparam int OFF_W  = $clog2(MAX_BLOCK_WORDS);
    localparam int ADDR_W = 16;
    localparam int TAG_W  = 16;
    localparam int DATA_W = 32;
    localparam int RANK_W = 3;
    localparam int DADDR_W = SET_W + WAY_W + OFF_W;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;

    localparam logic [2:0] ACT_READ  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_REQ   = 3'd2;
    localparam logic [2:0] ACT_WB    = 3'd3;
    localparam logic [2:0] ACT_EVICT = 3'd4;

    localparam logic [1:0] CFG_BLOCK = 2'd0;
    localparam logic [1:0] CFG_SETS  = 2'd1;
    localparam logic [1:0] CFG_WAYS  = 2'd2;

    typedef struct packed {
        logic              dirty;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
    } line_meta_t;

    typedef line_meta_t [MAX_WAYS-1:0] set_meta_t;
    typedef logic [MAX_WAYS-1:0][RANK_W-1:0] rank_vec_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic [WAY_W-1:0] victim;
    } way_sel_t;

    function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] a,
                                                 input logic [2:0] bl,
                                                 input logic [2:0] sl);
        logic [ADDR_W-1:0] m;
        m = (ADDR_W'(1) << sl) - ADDR_W'(1);
        return SET_W'((a >> bl) & m);
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] a,
                                                input logic [2:0] bl,
                                                input logic [2:0] sl);
        return TAG_W'((a >> bl) >> sl);
    endfunction

    function automatic logic [OFF_W-1:0] off_of(input logic [ADDR_W-1:0] a,
                                                input logic [2:0] bl);
        logic [ADDR_W-1:0] m;
        m = (ADDR_W'(1) << bl) - ADDR_W'(1);
        return OFF_W'(a & m);
    endfunction

endpackage

// ----- rtl/core/set_assoc_writeback_lru_cache_core.sv -----
// Write-back, write-allocate set-associative cache with LRU replacement:
// 16-bit word addresses, 32-bit words, up to 8 ways, 32 sets and 16-word
// blocks. Items are taken with start while busy is low; results come one per
// cycle on result_strobe, registered in the cycle after they are formed, and
// cannot be stalled. A hit goes through the tag read and, for a read, the
// registered data read. A miss goes through the tag read, one write-back
// result per word of a dirty victim, and the fill request; each fill word is
// taken on its own and the final one finishes the pending write or read.
// Writing any configuration register clears every line and any pending miss
// at once; cfg_ready is always high.
module set_assoc_writeback_lru_cache_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   op,
    input  logic [swlc_pkg::ADDR_W-1:0]  addr,
    input  logic [swlc_pkg::DATA_W-1:0]  store_data,
    input  logic [swlc_pkg::DATA_W-1:0]  fill_data,
    output logic                         result_strobe,
    output logic [2:0]                   action,
    output logic [swlc_pkg::ADDR_W-1:0]  mem_addr,
    output logic [4:0]                   size,
    output logic [swlc_pkg::DATA_W-1:0]  data,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [3:0]                   cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_META  = 3'd1;
    localparam logic [2:0] S_RDOUT = 3'd2;
    localparam logic [2:0] S_WB    = 3'd3;
    localparam logic [2:0] S_REQ   = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;

    localparam int SW = swlc_pkg::SET_W;
    localparam int WW = swlc_pkg::WAY_W;
    localparam int OW = swlc_pkg::OFF_W;
    localparam int AW = swlc_pkg::ADDR_W;
    localparam int DW = swlc_pkg::DATA_W;

    logic [2:0] state_reg, state_next;
    logic [2:0] bl_reg, sl_reg;
    logic [3:0] ways_reg;
    logic [swlc_pkg::MAX_SETS-1:0][swlc_pkg::MAX_WAYS-1:0] valid_reg, valid_next;

    logic [1:0]          op_reg, op_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [DW-1:0]       wdata_reg, wdata_next;
    logic [WW-1:0]       victim_reg, victim_next;
    logic [swlc_pkg::TAG_W-1:0] vtag_reg, vtag_next;
    logic [4:0]          wbcnt_reg, wbcnt_next;

    logic                pend_reg, pend_next;
    logic [AW-1:0]       paddr_reg, paddr_next;
    logic                pwrite_reg, pwrite_next;
    logic [DW-1:0]       pdata_reg, pdata_next;
    logic [WW-1:0]       pway_reg, pway_next;
    logic [4:0]          fcnt_reg, fcnt_next;

    logic                strobe_reg, strobe_next;
    logic [2:0]          action_reg, action_next;
    logic [AW-1:0]       maddr_reg, maddr_next;
    logic [4:0]          size_reg, size_next;
    logic [DW-1:0]       data_reg, data_next;
    logic                last_reg, last_next;

    logic                accept, cfg_we;
    logic [4:0]          bw;
    logic [SW-1:0]       cur_set, pset, mrd_set, mwr_set;
    logic [OW-1:0]       cur_off, poff;
    logic [AW-1:0]       evict_addr;

    logic                     meta_we;
    swlc_pkg::set_meta_t      meta_rd, meta_wr;
    logic                     dat_we;
    logic [swlc_pkg::DADDR_W-1:0] dat_waddr, dat_raddr;
    logic [DW-1:0]            dat_wdata, dat_rdata;

    swlc_pkg::way_sel_t       sel;
    swlc_pkg::rank_vec_t      ranks;
    logic                     use_hit;

    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    assign bw      = 5'(1) << bl_reg;
    assign cur_set = swlc_pkg::set_of(addr_reg, bl_reg, sl_reg);
    assign cur_off = swlc_pkg::off_of(addr_reg, bl_reg);
    assign pset    = swlc_pkg::set_of(paddr_reg, bl_reg, sl_reg);
    assign poff    = swlc_pkg::off_of(paddr_reg, bl_reg);
    assign evict_addr = ((vtag_reg << sl_reg) | AW'(cur_set)) << bl_reg;
    assign use_hit = state_reg != S_FILL;

    swlc_meta_ram u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (mwr_set),
        .wdata (meta_wr),
        .raddr (mrd_set),
        .rdata (meta_rd)
    );

    swlc_data_ram u_data (
        .clk   (clk),
        .we    (dat_we),
        .waddr (dat_waddr),
        .wdata (dat_wdata),
        .raddr (dat_raddr),
        .rdata (dat_rdata)
    );

    swlc_way_sel u_sel (
        .meta      (meta_rd),
        .valid     (valid_reg[use_hit ? cur_set : pset]),
        .ways      (ways_reg),
        .tag       (swlc_pkg::tag_of(addr_reg, bl_reg, sl_reg)),
        .use_hit   (use_hit),
        .touch_way (pway_reg),
        .sel       (sel),
        .ranks     (ranks)
    );

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        op_next     = op_reg;
        addr_next   = addr_reg;
        wdata_next  = wdata_reg;
        victim_next = victim_reg;
        vtag_next   = vtag_reg;
        wbcnt_next  = wbcnt_reg;
        pend_next   = pend_reg;
        paddr_next  = paddr_reg;
        pwrite_next = pwrite_reg;
        pdata_next  = pdata_reg;
        pway_next   = pway_reg;
        fcnt_next   = fcnt_reg;

        strobe_next = 1'b0;
        action_next = swlc_pkg::ACT_READ;
        maddr_next  = addr_reg;
        size_next   = 5'd1;
        data_next   = '0;
        last_next   = 1'b0;

        mrd_set   = (op == swlc_pkg::OP_FILL) ? pset : swlc_pkg::set_of(addr, bl_reg, sl_reg);
        mwr_set   = cur_set;
        meta_we   = 1'b0;
        meta_wr   = meta_rd;
        dat_we    = 1'b0;
        dat_waddr = {cur_set, sel.hit_way, cur_off};
        dat_wdata = wdata_reg;
        dat_raddr = {cur_set, sel.hit_way, cur_off};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((op == swlc_pkg::OP_READ || op == swlc_pkg::OP_WRITE) && !pend_reg)
                    begin
                        op_next    = op;
                        addr_next  = addr;
                        wdata_next = store_data;
                        state_next = S_META;
                    end
                    else if (op == swlc_pkg::OP_FILL && pend_reg)
                    begin
                        dat_we    = 1'b1;
                        dat_waddr = {pset, pway_reg, OW'(fcnt_reg) & OW'(bw - 5'd1)};
                        dat_wdata = fill_data;
                        fcnt_next = fcnt_reg + 5'd1;
                        if (fcnt_reg + 5'd1 == bw)
                        begin
                            state_next = S_FILL;
                        end
                    end
                end
            end
            S_META:
            begin
                if (sel.hit)
                begin
                    meta_we = 1'b1;
                    for (int i = 0; i < swlc_pkg::MAX_WAYS; i++)
                    begin
                        meta_wr[i].rank = ranks[i];
                    end
                    if (op_reg == swlc_pkg::OP_WRITE)
                    begin
                        meta_wr[sel.hit_way].dirty = 1'b1;
                        dat_we      = 1'b1;
                        strobe_next = 1'b1;
                        action_next = swlc_pkg::ACT_WRITE;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RDOUT;
                    end
                end
                else
                begin
                    victim_next = sel.victim;
                    vtag_next   = meta_rd[sel.victim].tag;
                    valid_next[cur_set][sel.victim] = 1'b0;
                    wbcnt_next  = '0;
                    dat_raddr   = {cur_set, sel.victim, OW'(0)};
                    if (valid_reg[cur_set][sel.victim] && meta_rd[sel.victim].dirty)
                    begin
                        state_next = S_WB;
                    end
                    else if (valid_reg[cur_set][sel.victim])
                    begin
                        strobe_next = 1'b1;
                        action_next = swlc_pkg::ACT_EVICT;
                        maddr_next  = ((meta_rd[sel.victim].tag << sl_reg)
                                       | AW'(cur_set)) << bl_reg;
                        size_next   = bw;
                        state_next  = S_REQ;
                    end
                    else
                    begin
                        state_next = S_REQ;
                    end
                end
            end
            S_RDOUT:
            begin
                strobe_next = 1'b1;
                action_next = swlc_pkg::ACT_READ;
                data_next   = dat_rdata;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_WB:
            begin
                strobe_next = 1'b1;
                action_next = swlc_pkg::ACT_WB;
                maddr_next  = evict_addr + AW'(wbcnt_reg);
                data_next   = dat_rdata;
                dat_raddr   = {cur_set, victim_reg, OW'(wbcnt_reg + 5'd1)};
                wbcnt_next  = wbcnt_reg + 5'd1;
                if (wbcnt_reg == bw - 5'd1)
                begin
                    state_next = S_REQ;
                end
            end
            S_REQ:
            begin
                strobe_next = 1'b1;
                action_next = swlc_pkg::ACT_REQ;
                maddr_next  = addr_reg - AW'(cur_off);
                size_next   = bw;
                last_next   = 1'b1;
                pend_next   = 1'b1;
                paddr_next  = addr_reg;
                pwrite_next = op_reg == swlc_pkg::OP_WRITE;
                pdata_next  = wdata_reg;
                pway_next   = victim_reg;
                fcnt_next   = '0;
                state_next  = S_IDLE;
            end
            S_FILL:
            begin
                mwr_set = pset;
                meta_we = 1'b1;
                for (int i = 0; i < swlc_pkg::MAX_WAYS; i++)
                begin
                    meta_wr[i].rank = ranks[i];
                end
                meta_wr[pway_reg].tag   = swlc_pkg::tag_of(paddr_reg, bl_reg, sl_reg);
                meta_wr[pway_reg].dirty = pwrite_reg;
                valid_next[pset][pway_reg] = 1'b1;
                pend_next  = 1'b0;
                fcnt_next  = '0;
                addr_next  = paddr_reg;
                dat_waddr  = {pset, pway_reg, poff};
                dat_wdata  = pdata_reg;
                dat_raddr  = {pset, pway_reg, poff};
                if (pwrite_reg)
                begin
                    dat_we      = 1'b1;
                    strobe_next = 1'b1;
                    action_next = swlc_pkg::ACT_WRITE;
                    maddr_next  = paddr_reg;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_RDOUT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we && cfg_index != 2'd3)
        begin
            valid_next = '0;
            pend_next  = 1'b0;
            fcnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            bl_reg     <= 3'd0;
            sl_reg     <= 3'd0;
            ways_reg   <= 4'd1;
            valid_reg  <= '0;
            pend_reg   <= 1'b0;
            fcnt_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            pend_reg   <= pend_next;
            fcnt_reg   <= fcnt_next;
            strobe_reg <= strobe_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    swlc_pkg::CFG_BLOCK:
                    begin
                        bl_reg <= (cfg_data[2:0] > 3'd4) ? 3'd4 : cfg_data[2:0];
                    end
                    swlc_pkg::CFG_SETS:
                    begin
                        sl_reg <= (cfg_data[2:0] > 3'd5) ? 3'd5 : cfg_data[2:0];
                    end
                    swlc_pkg::CFG_WAYS:
                    begin
                        ways_reg <= (cfg_data == 4'd0) ? 4'd1 :
                                    (cfg_data > 4'd8) ? 4'd8 : cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        wdata_reg  <= wdata_next;
        victim_reg <= victim_next;
        vtag_reg   <= vtag_next;
        wbcnt_reg  <= wbcnt_next;
        paddr_reg  <= paddr_next;
        pwrite_reg <= pwrite_next;
        pdata_reg  <= pdata_next;
        pway_reg   <= pway_next;
        action_reg <= action_next;
        maddr_reg  <= maddr_next;
        size_reg   <= size_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    assign result_strobe = strobe_reg;
    assign action        = action_reg;
    assign mem_addr      = maddr_reg;
    assign size          = size_reg;
    assign data          = data_reg;
    assign last          = last_reg;

endmodule

// ----- rtl/core/swlc_meta_ram.sv -----
module swlc_meta_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [swlc_pkg::SET_W-1:0] waddr,
    input  swlc_pkg::set_meta_t        wdata,
    input  logic [swlc_pkg::SET_W-1:0] raddr,
    output swlc_pkg::set_meta_t        rdata
);

    swlc_pkg::set_meta_t mem [swlc_pkg::MAX_SETS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/swlc_data_ram.sv -----
module swlc_data_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [swlc_pkg::DADDR_W-1:0] waddr,
    input  logic [swlc_pkg::DATA_W-1:0]  wdata,
    input  logic [swlc_pkg::DADDR_W-1:0] raddr,
    output logic [swlc_pkg::DATA_W-1:0]  rdata
);

    logic [swlc_pkg::DATA_W-1:0] mem [2**swlc_pkg::DADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/swlc_way_sel.sv -----
module swlc_way_sel (
    input  swlc_pkg::set_meta_t             meta,
    input  logic [swlc_pkg::MAX_WAYS-1:0]   valid,
    input  logic [3:0]                      ways,
    input  logic [swlc_pkg::TAG_W-1:0]      tag,
    input  logic                            use_hit,
    input  logic [swlc_pkg::WAY_W-1:0]      touch_way,
    output swlc_pkg::way_sel_t              sel,
    output swlc_pkg::rank_vec_t             ranks
);

    logic                           found;
    logic [swlc_pkg::RANK_W-1:0]    best;
    logic [swlc_pkg::WAY_W-1:0]     tw;
    logic [3:0]                     old;

    always_comb
    begin
        sel   = '0;
        found = 1'b0;
        best  = '0;
        for (int i = 0; i < swlc_pkg::MAX_WAYS; i++)
        begin
            if (i < int'(ways) && valid[i] && meta[i].tag == tag && !sel.hit)
            begin
                sel.hit     = 1'b1;
                sel.hit_way = swlc_pkg::WAY_W'(i);
            end
        end
        for (int i = 0; i < swlc_pkg::MAX_WAYS; i++)
        begin
            if (i < int'(ways) && !valid[i] && !found)
            begin
                found      = 1'b1;
                sel.victim = swlc_pkg::WAY_W'(i);
            end
        end
        if (!found)
        begin
            for (int i = 0; i < swlc_pkg::MAX_WAYS; i++)
            begin
                if (i < int'(ways) && (i == 0 || meta[i].rank > best))
                begin
                    best       = meta[i].rank;
                    sel.victim = swlc_pkg::WAY_W'(i);
                end
            end
        end

        // hit keeps its old rank as the bound; a new line bounds at ways
        tw  = use_hit ? sel.hit_way : touch_way;
        old = use_hit ? {1'b0, meta[tw].rank} : ways;
        for (int i = 0; i < swlc_pkg::MAX_WAYS; i++)
        begin
            if (i == int'(tw))
            begin
                ranks[i] = '0;
            end
            else if (i < int'(ways) && valid[i] && {1'b0, meta[i].rank} < old)
            begin
                ranks[i] = meta[i].rank + swlc_pkg::RANK_W'(1);
            end
            else
            begin
                ranks[i] = meta[i].rank;
            end
        end
    end

endmodule

// ----- rtl/core/swlc_checker.sv -----
module swlc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_strobe,
    input logic [2:0] action,
    input logic       last
);

    a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> action <= swlc_pkg::ACT_EVICT)
        else $error("undefined action code");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (action == swlc_pkg::ACT_READ || action == swlc_pkg::ACT_WRITE
                          || action == swlc_pkg::ACT_REQ) |-> last)
        else $error("completing result without last");

    a_inner_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (action == swlc_pkg::ACT_WB || action == swlc_pkg::ACT_EVICT)
        |-> !last)
        else $error("victim result marked last");

    a_req_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && action == swlc_pkg::ACT_REQ |=> !result_strobe)
        else $error("result right after fill request");

endmodule

bind set_assoc_writeback_lru_cache_core swlc_checker u_swlc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_strobe (result_strobe),
    .action        (action),
    .last          (last)
);

// ----- test/cache_checker.sv -----
module cache_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  op,
    input  logic [15:0] addr,
    input  logic [31:0] store_data,
    input  logic [31:0] fill_data,
    input  logic        result_strobe,
    input  logic [2:0]  action,
    input  logic [15:0] mem_addr,
    input  logic [4:0]  size,
    input  logic [31:0] data,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    output int          errors,
    output int          outstanding
);

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] mem_addr;
        logic [4:0]  size;
        logic [31:0] data;
        logic        last;
    } cache_result_t;

    cache_result_t result_q[$];

    logic [2:0] blk_log2, set_log2;
    logic [3:0] way_cnt;
    logic       valid_a [256];
    logic       dirty_a [256];
    logic [15:0] tag_a  [256];
    logic [2:0] rank_a  [256];
    logic [31:0] word_a [4096];
    logic        miss_p;
    logic [15:0] miss_addr;
    logic        miss_wr;
    logic [31:0] miss_data;
    int          miss_way;
    int          fills;

    assign outstanding = result_q.size();

    function automatic int eff_blk();
        return (blk_log2 > 4) ? 4 : int'(blk_log2);
    endfunction

    function automatic int eff_set();
        return (set_log2 > 5) ? 5 : int'(set_log2);
    endfunction

    function automatic int eff_ways();
        if (way_cnt == 0) return 1;
        return (way_cnt > 8) ? 8 : int'(way_cnt);
    endfunction

    task automatic clear_all();
        for (int i = 0; i < 256; i++)
        begin
            valid_a[i] = 0; dirty_a[i] = 0; tag_a[i] = 0; rank_a[i] = 0;
        end
        miss_p = 0; miss_addr = 0; miss_wr = 0; miss_data = 0;
        miss_way = 0; fills = 0;
    endtask

    task automatic push(logic [2:0] a, logic [15:0] ad, logic [4:0] s,
                        logic [31:0] d, logic l);
        cache_result_t r;
        r.action = a; r.mem_addr = ad; r.size = s; r.data = d; r.last = l;
        result_q.push_back(r);
    endtask

    task automatic promote(int base, int w, int hit, bit was_valid);
        int old;
        old = was_valid ? int'(rank_a[base + hit]) : w;
        for (int i = 0; i < w; i++)
            if (i != hit && valid_a[base + i] && rank_a[base + i] < old)
                rank_a[base + i] = rank_a[base + i] + 1;
        rank_a[base + hit] = 0;
    endtask

    task automatic complete(int ln, int off, logic [15:0] a, logic wr,
                            logic [31:0] wd);
        if (wr)
        begin
            word_a[ln * 16 + off] = wd;
            dirty_a[ln] = 1;
            push(swlc_pkg::ACT_WRITE, a, 5'd1, 32'd0, 1'b1);
        end
        else
            push(swlc_pkg::ACT_READ, a, 5'd1, word_a[ln * 16 + off], 1'b1);
    endtask

    task automatic predict_access(logic [1:0] o, logic [15:0] a, logic [31:0] wd,
                                  logic [31:0] fd);
        int bl, sl, w, bw, ns, st, tg, off, base, vic, ln, best;
        logic [15:0] ea;
        bl = eff_blk(); sl = eff_set(); w = eff_ways();
        bw = 1 << bl; ns = 1 << sl;
        if (o == swlc_pkg::OP_FILL)
        begin
            if (!miss_p) return;
            st = (int'(miss_addr) >> bl) & (ns - 1);
            base = st * 8;
            ln = base + (miss_way % w);
            word_a[ln * 16 + (fills % bw)] = fd;
            fills++;
            if (fills < bw) return;
            tag_a[ln] = 16'((int'(miss_addr) >> bl) >> sl);
            dirty_a[ln] = 0;
            promote(base, w, miss_way % w, 0);
            valid_a[ln] = 1;
            miss_p = 0;
            fills = 0;
            complete(ln, int'(miss_addr) & (bw - 1), miss_addr, miss_wr, miss_data);
            return;
        end
        if (o == 2'd3 || miss_p) return;
        off = int'(a) & (bw - 1);
        st = (int'(a) >> bl) & (ns - 1);
        tg = (int'(a) >> bl) >> sl;
        base = st * 8;
        for (int i = 0; i < w; i++)
            if (valid_a[base + i] && int'(tag_a[base + i]) == tg)
            begin
                promote(base, w, i, 1);
                complete(base + i, off, a, o == swlc_pkg::OP_WRITE, wd);
                return;
            end
        vic = w;
        for (int i = 0; i < w; i++)
            if (!valid_a[base + i])
            begin
                vic = i;
                break;
            end
        if (vic == w)
        begin
            best = 0; vic = 0;
            for (int i = 0; i < w; i++)
                if (i == 0 || rank_a[base + i] > best)
                begin
                    best = rank_a[base + i];
                    vic = i;
                end
        end
        ln = base + vic;
        if (valid_a[ln])
        begin
            ea = 16'(((int'(tag_a[ln]) << sl) | st) << bl);
            if (dirty_a[ln])
                for (int i = 0; i < bw; i++)
                    push(swlc_pkg::ACT_WB, ea + 16'(i), 5'd1, word_a[ln * 16 + i], 1'b0);
            else
                push(swlc_pkg::ACT_EVICT, ea, 5'(bw), 32'd0, 1'b0);
        end
        valid_a[ln] = 0;
        dirty_a[ln] = 0;
        push(swlc_pkg::ACT_REQ, a - 16'(off), 5'(bw), 32'd0, 1'b1);
        miss_p = 1; miss_addr = a; miss_wr = (o == swlc_pkg::OP_WRITE);
        miss_data = wd; miss_way = vic; fills = 0;
    endtask

    always @(posedge clk)
    begin
        cache_result_t got, exp_r;
        if (!rst_n)
        begin
            errors = 0;
            blk_log2 = 0; set_log2 = 0; way_cnt = 1;
            clear_all();
            result_q.delete();
        end
        else
        begin
            if (result_strobe)
            begin
                got.action = action; got.mem_addr = mem_addr; got.size = size;
                got.data = data; got.last = last;
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (got !== exp_r)
                    begin
                        $display("%0t: mismatch expected act=%0d addr=%h size=%0d data=%h last=%0d actual act=%0d addr=%h size=%0d data=%h last=%0d",
                                 $time, exp_r.action, exp_r.mem_addr, exp_r.size,
                                 exp_r.data, exp_r.last, got.action, got.mem_addr,
                                 got.size, got.data, got.last);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                predict_access(op, addr, store_data, fill_data);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    swlc_pkg::CFG_BLOCK: blk_log2 = cfg_data[2:0];
                    swlc_pkg::CFG_SETS:  set_log2 = cfg_data[2:0];
                    swlc_pkg::CFG_WAYS:  way_cnt = cfg_data;
                    default: ;
                endcase
                if (cfg_index != 2'd3) clear_all();
            end
        end
    end
endmodule

// ----- test/tb_top.sv -----
module tb_top;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  op = 0;
    logic [15:0] addr = 0;
    logic [31:0] store_data = 0;
    logic [31:0] fill_data = 0;
    logic        result_strobe;
    logic [2:0]  action;
    logic [15:0] mem_addr;
    logic [4:0]  size;
    logic [31:0] data;
    logic        last;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 0;
    logic [3:0]  cfg_data = 0;
    int          errors;
    int          outstanding;
    int          cycles = 0;
    logic [15:0] addr_pool[8];
    int          cur_bw;

    always #6 clk = ~clk;

    set_assoc_writeback_lru_cache_core u_top (.*);

    cache_checker u_chk (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_item(logic [1:0] o, logic [15:0] a, logic [31:0] wd,
                             logic [31:0] fd);
        start <= 1; op <= o; addr <= a; store_data <= wd; fill_data <= fd;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 0;
        idle_gap();
    endtask

    task automatic settle();
        while (outstanding != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] v);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic set_geometry(logic [3:0] b, logic [3:0] s, logic [3:0] w);
        write_reg(swlc_pkg::CFG_BLOCK, b);
        write_reg(swlc_pkg::CFG_SETS, s);
        write_reg(swlc_pkg::CFG_WAYS, w);
        cur_bw = 1 << ((b[2:0] > 4) ? 4 : b[2:0]);
    endtask

    // access, then its fill words when it misses
    task automatic access(logic [1:0] o, logic [15:0] a);
        send_item(o, a, $urandom, $urandom);
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        if (u_chk.miss_p)
            repeat (cur_bw) send_item(swlc_pkg::OP_FILL, 16'($urandom), $urandom, $urandom);
    endtask

    task automatic random_phase(int n);
        int pick;
        for (int i = 0; i < 8; i++) addr_pool[i] = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_item(2'd3, 16'($urandom), $urandom, $urandom);
            else if (pick == 1)
                send_item(swlc_pkg::OP_FILL, 16'($urandom), $urandom, $urandom);
            else if (pick < 4)
                access(2'($urandom_range(0, 1)), 16'($urandom));
            else
                access(2'($urandom_range(0, 1)),
                       addr_pool[$urandom_range(0, 7)] ^ 16'($urandom_range(0, 3)));
        end
        settle();
    endtask

    initial
    begin
        cur_bw = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        set_geometry(4'd2, 4'd1, 4'd2);
        access(swlc_pkg::OP_WRITE, 16'h0000);
        access(swlc_pkg::OP_WRITE, 16'hFFFF);
        send_item(swlc_pkg::OP_WRITE, 16'h1234, 32'hFFFFFFFF, 32'h0);
        send_item(swlc_pkg::OP_READ, 16'h1000, 32'h0, 32'h0);
        send_item(swlc_pkg::OP_FILL, 16'h0, 32'h0, 32'hFFFFFFFF);
        send_item(swlc_pkg::OP_FILL, 16'h0, 32'h0, 32'h0);
        send_item(swlc_pkg::OP_FILL, 16'h0, 32'h0, 32'hA5A5A5A5);
        send_item(swlc_pkg::OP_FILL, 16'h0, 32'h0, 32'h5A5A5A5A);
        access(swlc_pkg::OP_READ, 16'h1234);
        access(swlc_pkg::OP_READ, 16'h0001);
        access(swlc_pkg::OP_READ, 16'h8001);
        access(swlc_pkg::OP_READ, 16'h4000);
        access(swlc_pkg::OP_WRITE, 16'hC003);
        send_item(2'd3, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_item(swlc_pkg::OP_FILL, 16'h0, 32'h0, 32'h1);
        settle();
        set_geometry(4'd7, 4'd7, 4'd15);
        random_phase(8);
        set_geometry(4'd0, 4'd0, 4'd0);
        random_phase(30);
        set_geometry(4'd4, 4'd5, 4'd8);
        random_phase(8);
        set_geometry(4'd1, 4'd3, 4'd4);
        random_phase(30);
        set_geometry(4'd0, 4'd2, 4'd3);
        random_phase(30);
        write_reg(2'd3, 4'd9);
        random_phase(20);
        settle();
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/swlc_pkg.sv
rtl/core/swlc_meta_ram.sv
rtl/core/swlc_data_ram.sv
rtl/core/swlc_way_sel.sv
rtl/core/set_assoc_writeback_lru_cache_core.sv
rtl/core/swlc_checker.sv
test/cache_checker.sv
test/tb_top.sv
